// ===== design/natural_order_string_compare_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef NATURAL_ORDER_STRING_COMPARE_ASSERT_SVH
`define NATURAL_ORDER_STRING_COMPARE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NOSC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NOSC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("%m: assertion failed");

`endif

// ===== design/nosc_pkg.sv =====
`default_nettype none

package nosc_pkg;

    localparam int DEF_VALUE_BITS      = 31;
    localparam int DEF_RUN_LENGTH_BITS = 16;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef logic signed [1:0] t_order;

    localparam t_order ORDER_LESS    = 2'sb11;
    localparam t_order ORDER_EQUAL   = 2'sb00;
    localparam t_order ORDER_GREATER = 2'sb01;

    typedef enum logic [1:0] {
        LATER_NONE  = 2'b00,
        LATER_LEFT  = 2'b01,
        LATER_RIGHT = 2'b10
    } t_later;

    typedef struct packed {
        logic [7:0] left_char;
        logic       left_present;
        logic [7:0] right_char;
        logic       right_present;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_order order;
        logic   overflow;
    } t_out_word;

    typedef struct packed {
        logic   decide;
        t_order order;
    } t_settle;

endpackage

`default_nettype wire

// ===== design/nosc_run.sv =====
`default_nettype none

module nosc_run #(
    parameter int VALUE_BITS      = nosc_pkg::DEF_VALUE_BITS,
    parameter int RUN_LENGTH_BITS = nosc_pkg::DEF_RUN_LENGTH_BITS
) (
    input  logic [7:0]                 i_char,
    input  logic [VALUE_BITS-1:0]      i_value,
    input  logic [RUN_LENGTH_BITS-1:0] i_length,
    output logic                       o_digit,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic [RUN_LENGTH_BITS-1:0] o_length,
    output logic                       o_overflow
);
    import nosc_pkg::*;

    localparam int WIDE = VALUE_BITS + 4;

    logic [WIDE-1:0] w_value_wide;
    logic [WIDE-1:0] w_product;

    // The value times ten is formed from two shifts.
    assign w_value_wide = {4'b0000, i_value};
    assign w_product    = (w_value_wide << 3) + (w_value_wide << 1)
                        + {{(WIDE-4){1'b0}}, i_char[3:0]};

    assign o_digit    = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign o_overflow = |w_product[WIDE-1:VALUE_BITS];
    assign o_value    = o_overflow ? {VALUE_BITS{1'b1}} : w_product[VALUE_BITS-1:0];
    assign o_length   = (&i_length) ? i_length : i_length + 1'b1;

endmodule

`default_nettype wire

// ===== design/natural_order_string_compare.sv =====
`default_nettype none

// Natural-order comparator of two byte strings fed one position per word. Words are taken
// at one per cycle while input ready is high; each passes an input register and then
// updates the compare state, the digit run values growing by a shift-and-add times ten.
// The word marked last writes the order (-1, 0 or +1) and the overflow flag into the
// result register on leaving the input register; the state clears for the next compare.
// Input ready drops only while a last word waits for the result register to be emptied.
module natural_order_string_compare #(
    parameter int VALUE_BITS      = nosc_pkg::DEF_VALUE_BITS,
    parameter int RUN_LENGTH_BITS = nosc_pkg::DEF_RUN_LENGTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  nosc_pkg::t_in_word  i_in_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output nosc_pkg::t_out_word o_out_data,
    input  logic                i_out_ready
);
    import nosc_pkg::*;

    logic                       r_in_valid;
    t_in_word                   r_in;
    logic                       r_out_valid;
    t_out_word                  r_out;

    logic                       r_decided,   n_decided;
    t_order                     r_verdict,   n_verdict;
    logic                       r_in_number, n_in_number;
    logic                       r_lopen,     n_lopen;
    logic                       r_ropen,     n_ropen;
    logic [VALUE_BITS-1:0]      r_lval,      n_lval;
    logic [VALUE_BITS-1:0]      r_rval,      n_rval;
    logic [RUN_LENGTH_BITS-1:0] r_llen,      n_llen;
    logic [RUN_LENGTH_BITS-1:0] r_rlen,      n_rlen;
    logic                       r_ovf,       n_ovf;

    logic                       w_adv;
    logic                       w_go;
    logic                       w_cont_l, w_cont_r;
    t_later                     w_later, w_final_later;
    t_settle                    w_settle, w_final_settle;
    t_order                     w_final_order;

    logic                       w_l_digit, w_r_digit;
    logic [VALUE_BITS-1:0]      w_l_acc, w_r_acc;
    logic [RUN_LENGTH_BITS-1:0] w_l_len, w_r_len;
    logic                       w_l_ovf, w_r_ovf;

    function automatic t_settle settle(
        input logic [VALUE_BITS-1:0]      lv,
        input logic [VALUE_BITS-1:0]      rv,
        input logic [RUN_LENGTH_BITS-1:0] ll,
        input logic [RUN_LENGTH_BITS-1:0] rl,
        input t_later                     later
    );
        t_settle s;
        s.decide = 1'b1;
        s.order  = ORDER_EQUAL;
        if (lv != rv) begin
            s.order = (lv < rv) ? ORDER_LESS : ORDER_GREATER;
        end else if (ll != rl) begin
            s.order = (ll > rl) ? ORDER_LESS : ORDER_GREATER;
        end else begin
            case (later)
                LATER_LEFT:  s.order = ORDER_LESS;
                LATER_RIGHT: s.order = ORDER_GREATER;
                default:     s.decide = 1'b0;
            endcase
        end
        return s;
    endfunction

    nosc_run #(
        .VALUE_BITS      (VALUE_BITS),
        .RUN_LENGTH_BITS (RUN_LENGTH_BITS)
    ) u_left_run (
        .i_char     (r_in.left_char),
        .i_value    (r_lval),
        .i_length   (r_llen),
        .o_digit    (w_l_digit),
        .o_value    (w_l_acc),
        .o_length   (w_l_len),
        .o_overflow (w_l_ovf)
    );

    nosc_run #(
        .VALUE_BITS      (VALUE_BITS),
        .RUN_LENGTH_BITS (RUN_LENGTH_BITS)
    ) u_right_run (
        .i_char     (r_in.right_char),
        .i_value    (r_rval),
        .i_length   (r_rlen),
        .o_digit    (w_r_digit),
        .o_value    (w_r_acc),
        .o_length   (w_r_len),
        .o_overflow (w_r_ovf)
    );

    assign w_adv      = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_cont_l = r_lopen && r_in.left_present && w_l_digit;
    assign w_cont_r = r_ropen && r_in.right_present && w_r_digit;
    assign w_later  = (r_lopen && r_ropen) ? LATER_NONE :
                      (r_lopen ? LATER_LEFT : LATER_RIGHT);
    assign w_settle = settle(r_lval, r_rval, r_llen, r_rlen, w_later);

    always_comb begin
        n_decided   = r_decided;
        n_verdict   = r_verdict;
        n_in_number = r_in_number;
        n_lopen     = r_lopen;
        n_ropen     = r_ropen;
        n_lval      = r_lval;
        n_rval      = r_rval;
        n_llen      = r_llen;
        n_rlen      = r_rlen;
        n_ovf       = r_ovf;
        w_go        = !r_decided;

        if (!r_decided && r_in_number) begin
            if (w_cont_l) begin
                n_lval = w_l_acc;
                n_llen = w_l_len;
                n_ovf  = n_ovf | w_l_ovf;
            end
            if (w_cont_r) begin
                n_rval = w_r_acc;
                n_rlen = w_r_len;
                n_ovf  = n_ovf | w_r_ovf;
            end
            n_lopen = w_cont_l;
            n_ropen = w_cont_r;
            if (!w_cont_l && !w_cont_r) begin
                n_in_number = 1'b0;
                if (w_settle.decide) begin
                    n_decided = 1'b1;
                    n_verdict = w_settle.order;
                    w_go      = 1'b0;
                end
            end else begin
                w_go = 1'b0;
            end
        end

        if (w_go) begin
            if (r_in.left_present && r_in.right_present) begin
                if (w_l_digit && w_r_digit) begin
                    n_in_number = 1'b1;
                    n_lopen     = 1'b1;
                    n_ropen     = 1'b1;
                    n_lval      = {{(VALUE_BITS-4){1'b0}}, r_in.left_char[3:0]};
                    n_rval      = {{(VALUE_BITS-4){1'b0}}, r_in.right_char[3:0]};
                    n_llen      = {{(RUN_LENGTH_BITS-1){1'b0}}, 1'b1};
                    n_rlen      = {{(RUN_LENGTH_BITS-1){1'b0}}, 1'b1};
                end else if ($signed(r_in.left_char) < $signed(r_in.right_char)) begin
                    n_decided = 1'b1;
                    n_verdict = ORDER_LESS;
                end else if ($signed(r_in.right_char) < $signed(r_in.left_char)) begin
                    n_decided = 1'b1;
                    n_verdict = ORDER_GREATER;
                end
            end else if (r_in.left_present) begin
                n_decided = 1'b1;
                n_verdict = ORDER_GREATER;
            end else if (r_in.right_present) begin
                n_decided = 1'b1;
                n_verdict = ORDER_LESS;
            end
        end
    end

    assign w_final_later  = (n_lopen && n_ropen) ? LATER_NONE :
                            (n_lopen ? LATER_LEFT : LATER_RIGHT);
    assign w_final_settle = settle(n_lval, n_rval, n_llen, n_rlen, w_final_later);
    assign w_final_order  = (!n_decided && n_in_number && w_final_settle.decide) ?
                            w_final_settle.order : n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_decided   <= 1'b0;
            r_verdict   <= ORDER_EQUAL;
            r_in_number <= 1'b0;
            r_lopen     <= 1'b0;
            r_ropen     <= 1'b0;
            r_lval      <= '0;
            r_rval      <= '0;
            r_llen      <= '0;
            r_rlen      <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv && r_in.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                if (r_in.last) begin
                    r_decided   <= 1'b0;
                    r_verdict   <= ORDER_EQUAL;
                    r_in_number <= 1'b0;
                    r_lopen     <= 1'b0;
                    r_ropen     <= 1'b0;
                    r_lval      <= '0;
                    r_rval      <= '0;
                    r_llen      <= '0;
                    r_rlen      <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_decided   <= n_decided;
                    r_verdict   <= n_verdict;
                    r_in_number <= n_in_number;
                    r_lopen     <= n_lopen;
                    r_ropen     <= n_ropen;
                    r_lval      <= n_lval;
                    r_rval      <= n_rval;
                    r_llen      <= n_llen;
                    r_rlen      <= n_rlen;
                    r_ovf       <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_adv && r_in.last) begin
            r_out.order    <= w_final_order;
            r_out.overflow <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/nosc_checker.sv =====
`default_nettype none

`include "natural_order_string_compare_assert.svh"

module nosc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire nosc_pkg::t_in_word  i_in_data,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire nosc_pkg::t_out_word o_out_data,
    input wire logic                i_out_ready
);
    import nosc_pkg::*;

    logic w_in_take;
    logic w_order_ok;

    assign w_in_take  = i_in_valid && o_in_ready && i_in_data.last;
    assign w_order_ok = (o_out_data.order == ORDER_LESS) || (o_out_data.order == ORDER_EQUAL)
                     || (o_out_data.order == ORDER_GREATER);

    // A result only ever carries one of the three order codes.
    `NOSC_ASSERT_NOW(a_order_legal, i_clk, i_rst_n, o_out_valid, w_order_ok)

    // With the result register empty, nothing can hold back the input.
    `NOSC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // A result that is not taken stays put.
    `NOSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // A result that fills an empty result register comes from a last word taken into the input register.
    `NOSC_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid), $past(w_in_take, 2))

endmodule

bind natural_order_string_compare nosc_checker u_nosc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
